/* design/pths_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic task heap scheduler package
// Shared sizes, codes, item types and a helper function for the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pths_pkg;

	// Table size and due time width.
	localparam int CAPACITY  = 1024;
	localparam int TIME_BITS = 48;

	// Widths: heap index and entry count (derived), task id, period, reported due time.
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ID_W  = 16;
	localparam int PER_W = 16;
	localparam int DUE_W = 48;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Operation codes.
	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_EMIT     = 2'd1;
	localparam logic [1:0] OP_CLEAR    = 2'd2;

	// Status codes.
	localparam logic [2:0] STAT_REGISTERED = 3'd0;
	localparam logic [2:0] STAT_EMITTED    = 3'd1;
	localparam logic [2:0] STAT_FULL       = 3'd2;
	localparam logic [2:0] STAT_EMPTY      = 3'd3;
	localparam logic [2:0] STAT_CLEARED    = 3'd4;

	// One heap entry.
	typedef struct packed {
		logic [TIME_BITS-1:0] due;
		logic [ID_W-1:0]      id;
		logic [PER_W-1:0]     period;
	} entry_t;

	// Input transfer payload.
	typedef struct packed {
		logic [1:0]       op;
		logic [ID_W-1:0]  task_id;
		logic [PER_W-1:0] period;
	} in_item_t;

	// Output transfer payload.
	typedef struct packed {
		logic [2:0]       status;
		logic [ID_W-1:0]  out_id;
		logic [DUE_W-1:0] due_time;
	} out_item_t;

	// Advance a due time by a period, saturating at the largest time.
	function automatic logic [TIME_BITS-1:0] sat_add(
		input logic [TIME_BITS-1:0] due,
		input logic [PER_W-1:0]     per
	);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, due} + (TIME_BITS+1)'(per);
		return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/pths_key_cmp.sv */
// ----------------------------------------------------------------------------
// Heap key comparator
// Compares two entries by due time, then by id; true when a is strictly less.
// ----------------------------------------------------------------------------
`default_nettype none

module pths_key_cmp
	import pths_pkg::*;
(
	input  wire entry_t a,
	input  wire entry_t b,
	output logic        less
);

	// Lexicographic compare of (due, id).
	always_comb begin
		less = (a.due < b.due) || ((a.due == b.due) && (a.id < b.id));
	end

endmodule

`default_nettype wire

/* design/periodic_task_heap_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Periodic task heap scheduler core
// Min-heap of periodic tasks keyed by (due time, id), run by a sequencer
// around one shared key comparator and a two-read, one-write table memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one command (register, emit, clear) per transfer.
//   out_valid/out_ready carry one status result per command; an unknown op
//   gives no result. Only one command is in work at a time.
//   Steps: clear, full and empty answers go straight to the finish step.
//   A register command climbs from the new last position, reading and
//   comparing the parent at each level until it reaches the root or stops.
//   An emit fetches the root and last entry, sifts the last entry down,
//   picking the smaller child and comparing with it at each level until
//   it settles, then puts the task back with its due time advanced and
//   climbs it as for a register. The finish step waits for a free output
//   register and returns to idle as it loads the result there, so the next
//   command can be taken in the following cycle.
//   Reset empties the table at once; the memory itself is not cleared.
//   A new command is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the following result is held
//   inside until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_heap_scheduler_core
	import pths_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	localparam int CW = IDX_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_LD,
		ST_DN_RD,
		ST_DN_SEL,
		ST_DN_CMP,
		ST_UP_CHK,
		ST_UP_CMP,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   cidx_q;
	logic               r_ok_q;
	entry_t             mov_q;
	entry_t             push_q;
	entry_t             child_q;
	out_item_t          res_q;
	out_item_t          out_q;
	logic               out_valid_q;

	// Table memory and its registered read ports.
	entry_t             heap_mem_q [CAPACITY];
	entry_t             rd0_q;
	entry_t             rd1_q;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	entry_t             mem_wdata;
	logic [IDX_W-1:0]   mem_raddr0;
	logic [IDX_W-1:0]   mem_raddr1;

	entry_t             cmp_a;
	entry_t             cmp_b;
	logic               cmp_less;

	logic               in_xfer;
	logic               out_free;
	logic [CW-1:0]      l_ext;
	logic [CW-1:0]      r_ext;
	logic [CW-1:0]      cnt_ext;
	logic               l_ok;
	logic               r_ok;
	logic [IDX_W-1:0]   km1;
	logic [IDX_W-1:0]   par_idx;
	logic [CNT_W-1:0]   cnt_m1;
	entry_t             new_entry;
	entry_t             readd_entry;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Heap index arithmetic around the current position.
	assign l_ext   = CW'({k_q, 1'b1});
	assign r_ext   = l_ext + CW'(1);
	assign cnt_ext = CW'(count_q);
	assign l_ok    = l_ext < cnt_ext;
	assign r_ok    = r_ext < cnt_ext;
	assign km1     = k_q - IDX_W'(1);
	assign par_idx = {1'b0, km1[IDX_W-1:1]};
	assign cnt_m1  = count_q - CNT_W'(1);

	// Entry for a newly registered task, and a popped task put back.
	assign new_entry.due      = TIME_BITS'(in_data.period);
	assign new_entry.id       = in_data.task_id;
	assign new_entry.period   = in_data.period;
	assign readd_entry.due    = sat_add(rd0_q.due, rd0_q.period);
	assign readd_entry.id     = rd0_q.id;
	assign readd_entry.period = rd0_q.period;

	// Shared key comparator.
	pths_key_cmp u_key_cmp (
		.a    (cmp_a),
		.b    (cmp_b),
		.less (cmp_less)
	);

	// Comparator operands and memory port controls per sequencer step.
	always_comb begin
		cmp_a      = mov_q;
		cmp_b      = rd0_q;
		mem_we     = 1'b0;
		mem_waddr  = k_q;
		mem_wdata  = mov_q;
		mem_raddr0 = '0;
		mem_raddr1 = '0;
		case (state_q)
			ST_IDLE: begin
				mem_raddr0 = '0;
				mem_raddr1 = cnt_m1[IDX_W-1:0];
			end
			ST_DN_RD: begin
				mem_raddr0 = l_ext[IDX_W-1:0];
				mem_raddr1 = r_ok ? r_ext[IDX_W-1:0] : l_ext[IDX_W-1:0];
				mem_we     = !l_ok;
			end
			ST_DN_SEL: begin
				cmp_a = rd1_q;
				cmp_b = rd0_q;
			end
			ST_DN_CMP: begin
				cmp_a     = child_q;
				cmp_b     = mov_q;
				mem_we    = 1'b1;
				mem_wdata = cmp_less ? child_q : mov_q;
			end
			ST_UP_CHK: begin
				mem_raddr0 = par_idx;
				mem_we     = (k_q == '0);
			end
			ST_UP_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = cmp_less ? rd0_q : mov_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Table memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			heap_mem_q[mem_waddr] <= mem_wdata;
		end
		rd0_q <= heap_mem_q[mem_raddr0];
		rd1_q <= heap_mem_q[mem_raddr1];
	end

	// Sequencer, table count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			cidx_q      <= '0;
			r_ok_q      <= 1'b0;
			mov_q       <= '0;
			push_q      <= '0;
			child_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The finish step reloads the output register itself.
			if (out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						res_q.out_id   <= '0;
						res_q.due_time <= '0;
						case (in_data.op)
							OP_REGISTER: begin
								if (count_q == CNT_W'(CAPACITY)) begin
									res_q.status <= STAT_FULL;
									state_q      <= ST_FINISH;
								end else begin
									res_q.status <= STAT_REGISTERED;
									mov_q        <= new_entry;
									k_q          <= count_q[IDX_W-1:0];
									count_q      <= count_q + CNT_W'(1);
									state_q      <= ST_UP_CHK;
								end
							end
							OP_EMIT: begin
								if (count_q == '0) begin
									res_q.status <= STAT_EMPTY;
									state_q      <= ST_FINISH;
								end else begin
									count_q <= cnt_m1;
									state_q <= ST_POP_LD;
								end
							end
							OP_CLEAR: begin
								count_q      <= '0;
								res_q.status <= STAT_CLEARED;
								state_q      <= ST_FINISH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				// Root and last entry have arrived: report the root.
				ST_POP_LD: begin
					res_q.status   <= STAT_EMITTED;
					res_q.out_id   <= rd0_q.id;
					res_q.due_time <= DUE_W'(rd0_q.due);
					k_q            <= '0;
					if (count_q == '0) begin
						mov_q   <= readd_entry;
						count_q <= CNT_W'(1);
						state_q <= ST_UP_CHK;
					end else begin
						mov_q   <= rd1_q;
						push_q  <= readd_entry;
						state_q <= ST_DN_RD;
					end
				end
				// Fetch children, or settle the moving entry at a leaf.
				ST_DN_RD: begin
					r_ok_q <= r_ok;
					if (l_ok) begin
						state_q <= ST_DN_SEL;
					end else begin
						mov_q   <= push_q;
						k_q     <= count_q[IDX_W-1:0];
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_UP_CHK;
					end
				end
				// Pick the right child only when it is strictly smaller.
				ST_DN_SEL: begin
					if (r_ok_q && cmp_less) begin
						child_q <= rd1_q;
						cidx_q  <= r_ext[IDX_W-1:0];
					end else begin
						child_q <= rd0_q;
						cidx_q  <= l_ext[IDX_W-1:0];
					end
					state_q <= ST_DN_CMP;
				end
				// Move the child up, or settle and start putting the task back.
				ST_DN_CMP: begin
					if (cmp_less) begin
						k_q     <= cidx_q;
						state_q <= ST_DN_RD;
					end else begin
						mov_q   <= push_q;
						k_q     <= count_q[IDX_W-1:0];
						count_q <= count_q + CNT_W'(1);
						state_q <= ST_UP_CHK;
					end
				end
				// At the root the entry is written; otherwise fetch the parent.
				ST_UP_CHK: begin
					if (k_q == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_UP_CMP;
					end
				end
				// Move the parent down while the new entry is strictly smaller.
				ST_UP_CMP: begin
					if (cmp_less) begin
						k_q     <= par_idx;
						state_q <= ST_UP_CHK;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				// Hand the result to the output register once it is free.
				ST_FINISH: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The entry count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A sift-down step always works on a position inside the heap.
	a_sift_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DN_RD) |-> (CNT_W'(k_q) < count_q))
		else $error("sift-down position outside the heap");

	// A successful register transfer grows the table by one entry.
	a_register_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_data.op == OP_REGISTER && count_q != CNT_W'(CAPACITY))
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("register transfer did not add an entry");

	// A finished result reaches the output once the output register is free.
	a_result_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not loaded into the output register");

endmodule

`default_nettype wire
